FILE: rtl/sha_pkg.sv
// Package for the SHA-256 byte stream hasher: types, constants and round functions.
// Used by the controller, the datapath and the top level.
package sha_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_PAD,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_PAD_BYTE,
    OP_START,
    OP_ROUND,
    OP_FOLD,
    OP_LENGTH,
    OP_RESTART
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] pad_byte;
    logic [5:0] round;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] byte_pos;
  } dp_stat_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic word_t ror(input word_t v, input int unsigned s);
    ror = (v >> s) | (v << (32 - s));
  endfunction

  function automatic word_t ssig0(input word_t v);
    ssig0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t ssig1(input word_t v);
    ssig1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t bsig0(input word_t v);
    bsig0 = ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
  endfunction

  function automatic word_t bsig1(input word_t v);
    bsig1 = ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
  endfunction

endpackage

FILE: rtl/sha_byte_if.sv
// Valid/ready channels of the hasher: message bytes in, digest words out.
// Depends on nothing.
interface sha_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       msg_end;
  modport source (output valid, data_byte, byte_present, msg_end, input ready);
  modport sink (input valid, data_byte, byte_present, msg_end, output ready);
endinterface

interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/sha_datapath.sv
// Datapath of the hasher: block buffer, schedule window, working and chaining registers.
// Depends on sha_pkg; driven by commands from sha_ctrl.
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]        byte_i,
  output sha_pkg::dp_stat_t stat_o,
  input  logic [2:0]        rd_idx_i,
  output sha_pkg::word_t    rd_word_o
);

  sha_pkg::word_t blk_q [16];
  sha_pkg::word_t w_q [16];
  sha_pkg::word_t h_q [8];
  sha_pkg::word_t r_q [8];
  logic [63:0]    len_q;
  logic [5:0]     pos_q;

  sha_pkg::word_t w_cur, w_new, t1, t2;
  logic [3:0]     ri;
  logic [7:0]     wb;
  logic [63:0]    bits;

  assign ri = cmd_i.round[3:0];
  assign bits = {len_q[60:0], 3'b000};
  assign w_new = w_q[ri] + sha_pkg::ssig0(w_q[ri + 4'd1]) + w_q[ri + 4'd9]
               + sha_pkg::ssig1(w_q[ri + 4'd14]);
  assign w_cur = cmd_i.round[5:4] == 2'd0 ? w_q[ri] : w_new;
  assign t1 = r_q[7] + sha_pkg::bsig1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
            + sha_pkg::RoundK[cmd_i.round] + w_cur;
  assign t2 = sha_pkg::bsig0(r_q[0]) + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2])
            ^ (r_q[1] & r_q[2]));
  assign wb = cmd_i.op == sha_pkg::OP_BYTE ? byte_i : cmd_i.pad_byte;

  assign stat_o.byte_pos = pos_q;
  assign rd_word_o = h_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
      for (int i = 0; i < 8; i++) r_q[i] <= '0;
      for (int i = 0; i < 16; i++) blk_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else begin
      unique case (cmd_i.op)
        sha_pkg::OP_BYTE, sha_pkg::OP_PAD_BYTE: begin
          case (pos_q[1:0])
            2'd0: blk_q[pos_q[5:2]] <= {wb, 24'd0};
            2'd1: blk_q[pos_q[5:2]][23:16] <= wb;
            2'd2: blk_q[pos_q[5:2]][15:8] <= wb;
            default: blk_q[pos_q[5:2]][7:0] <= wb;
          endcase
          pos_q <= pos_q + 6'd1;
          if (cmd_i.op == sha_pkg::OP_BYTE) len_q <= len_q + 64'd1;
        end
        sha_pkg::OP_LENGTH: begin
          blk_q[14] <= bits[63:32];
          blk_q[15] <= bits[31:0];
        end
        sha_pkg::OP_START: begin
          for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
          for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
        end
        sha_pkg::OP_ROUND: begin
          w_q[ri] <= w_cur;
          for (int i = 1; i < 8; i++) r_q[i] <= r_q[i-1];
          r_q[4] <= r_q[3] + t1;
          r_q[0] <= t1 + t2;
        end
        sha_pkg::OP_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
        end
        sha_pkg::OP_RESTART: begin
          len_q <= '0;
          pos_q <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/sha_ctrl.sv
// Controller of the hasher: accepts requests, sequences rounds, padding and digest output.
// Depends on sha_pkg, sha_byte_if and sha_digest_if; commands sha_datapath.
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha_byte_if.sink          in_if,
  sha_digest_if.source      out_if,
  input  sha_pkg::dp_stat_t stat_i,
  input  sha_pkg::word_t    word_i,
  output sha_pkg::dp_cmd_t  cmd_o,
  output logic [2:0]        rd_idx_o
);

  sha_pkg::state_e state_q, state_d;
  logic [5:0] round_q, round_d;
  logic       fin_q, fin_d;      // message end pending
  logic       marked_q, marked_d; // 0x80 already placed
  logic [2:0] idx_q, idx_d;

  assign rd_idx_o = idx_q;
  assign out_if.word_index = idx_q;
  assign out_if.last_word = idx_q == 3'd7;
  assign out_if.digest_word = word_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      round_q <= '0;
      fin_q <= 1'b0;
      marked_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      fin_q <= fin_d;
      marked_q <= marked_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    fin_d = fin_q;
    marked_d = marked_q;
    idx_d = idx_q;
    cmd_o.op = sha_pkg::OP_NONE;
    cmd_o.pad_byte = '0;
    cmd_o.round = round_q;
    in_if.ready = 1'b0;
    out_if.valid = 1'b0;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid && in_if.byte_present) begin
          cmd_o.op = sha_pkg::OP_BYTE;
          fin_d = in_if.msg_end;
          marked_d = 1'b0;
          if (stat_i.byte_pos == 6'd63) state_d = sha_pkg::ST_LOAD;
          else if (in_if.msg_end) state_d = sha_pkg::ST_PAD;
        end else if (in_if.valid && in_if.msg_end) begin
          fin_d = 1'b1;
          marked_d = 1'b0;
          state_d = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_PAD: begin
        if (stat_i.byte_pos == sha_pkg::LenPos && marked_q) begin
          cmd_o.op = sha_pkg::OP_LENGTH;
          fin_d = 1'b0;
          state_d = sha_pkg::ST_LOAD;
        end else begin
          cmd_o.op = sha_pkg::OP_PAD_BYTE;
          cmd_o.pad_byte = marked_q ? 8'h00 : sha_pkg::PadMark;
          marked_d = 1'b1;
          if (stat_i.byte_pos == 6'd63) state_d = sha_pkg::ST_LOAD;
        end
      end
      sha_pkg::ST_LOAD: begin
        cmd_o.op = sha_pkg::OP_START;
        round_d = '0;
        state_d = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        cmd_o.op = sha_pkg::OP_ROUND;
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) state_d = sha_pkg::ST_FOLD;
      end
      sha_pkg::ST_FOLD: begin
        cmd_o.op = sha_pkg::OP_FOLD;
        idx_d = '0;
        if (fin_q) state_d = sha_pkg::ST_PAD;
        else if (marked_q) state_d = sha_pkg::ST_OUT;
        else state_d = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_OUT: begin
        out_if.valid = 1'b1;
        if (out_if.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.op = sha_pkg::OP_RESTART;
            marked_d = 1'b0;
            state_d = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Depends on sha_pkg, sha_byte_if, sha_digest_if, sha_ctrl and sha_datapath.
// A byte request that neither ends the message nor completes a block is taken and leaves
// the input ready for the next request. A byte that completes a 64-byte block holds the
// input off while the schedule is loaded, the 64 rounds run in a single round unit and
// the result is folded into the chaining words. An end request then writes the padding
// bytes at one per cycle up to byte 56 of the block, spending a further compression when
// the end falls at byte 56 or later, places the bit length and runs the last compression.
// The eight digest words follow, most significant first, one per cycle while the receiver
// takes them; no new request is accepted until the last digest word has been taken.
module sha256_byte_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha_byte_if.sink     in_if,
  sha_digest_if.source out_if
);

  sha_pkg::dp_cmd_t  cmd;
  sha_pkg::dp_stat_t stat;
  logic [2:0]        rd_idx;
  sha_pkg::word_t    rd_word;

  sha_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .out_if   (out_if),
    .stat_i   (stat),
    .word_i   (rd_word),
    .cmd_o    (cmd),
    .rd_idx_o (rd_idx)
  );

  sha_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .byte_i    (in_if.data_byte),
    .stat_o    (stat),
    .rd_idx_i  (rd_idx),
    .rd_word_o (rd_word)
  );

endmodule

FILE: tb/sha256_byte_stream_hasher_test.sv
// Self-checking test of the SHA-256 byte stream hasher: directed and random messages.
// A scoreboard class computes expected digests; depends on sha_pkg and the channel interfaces.
module sha256_byte_stream_hasher_test;

  class digest_scoreboard;
    sha_pkg::word_t chain [8];
    logic [7:0]     msg_bytes [$];
    sha_pkg::word_t digest_q [$];
    logic [2:0]     index_q [$];
    logic [63:0]    count;
    int             errors;

    function new();
      chain = sha_pkg::InitHash;
      count = '0;
      errors = 0;
    endfunction

    function sha_pkg::word_t rotr(sha_pkg::word_t v, int s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function void compress(sha_pkg::word_t blk [16]);
      sha_pkg::word_t w [64];
      sha_pkg::word_t r [8];
      sha_pkg::word_t t1, t2;
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w[t] = blk[t];
        end else begin
          w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
               + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        end
      end
      r = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
           + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_pkg::RoundK[t] + w[t];
        t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
           + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
        r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
        r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += r[i];
    endfunction

    function void take_block();
      sha_pkg::word_t blk [16];
      for (int i = 0; i < 16; i++)
        blk[i] = {msg_bytes[4*i], msg_bytes[4*i+1], msg_bytes[4*i+2], msg_bytes[4*i+3]};
      compress(blk);
      for (int i = 0; i < 64; i++) void'(msg_bytes.pop_front());
    endfunction

    function void note_request(logic [7:0] b, logic present, logic last);
      logic [63:0] bits;
      if (present) begin
        msg_bytes.insert(msg_bytes.size(), b);
        count++;
        if (msg_bytes.size() == 64) take_block();
      end
      if (!last) return;
      bits = count << 3;
      msg_bytes.insert(msg_bytes.size(), sha_pkg::PadMark);
      while (msg_bytes.size() % 64 != 56) msg_bytes.insert(msg_bytes.size(), 8'h00);
      for (int i = 7; i >= 0; i--) msg_bytes.insert(msg_bytes.size(), bits[8*i +: 8]);
      while (msg_bytes.size() > 0) take_block();
      for (int k = 0; k < 8; k++) begin
        digest_q.insert(digest_q.size(), chain[k]);
        index_q.insert(index_q.size(), k[2:0]);
      end
      chain = sha_pkg::InitHash;
      count = '0;
    endfunction

    function void check_word(sha_pkg::word_t d, logic [2:0] idx, logic lw);
      sha_pkg::word_t ed;
      logic [2:0] ei;
      if (digest_q.size() == 0) begin
        $error("digest word with no expectation: %h", d);
        errors++;
        return;
      end
      ed = digest_q.pop_front();
      ei = index_q.pop_front();
      if (d !== ed) begin
        $error("digest_word expected %h actual %h", ed, d); errors++;
      end
      if (idx !== ei) begin
        $error("word_index expected %0d actual %0d", ei, idx); errors++;
      end
      if (lw !== (ei == 3'd7)) begin
        $error("last_word expected %0d actual %0d", ei == 3'd7, lw); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sha_byte_if   in_if ();
  sha_digest_if out_if ();
  digest_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit watchdog_fired = 1'b0;

  sha256_byte_stream_hasher dut (.clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source));

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.byte_present = 1'b0;
    in_if.msg_end = 1'b0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_request(in_if.data_byte, in_if.byte_present, in_if.msg_end);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 5000 && !watchdog_fired) begin
      watchdog_fired = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  bit quiet_mode = 1'b0;

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (quiet_mode) begin
        out_if.ready <= 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_if.ready <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_request(logic [7:0] b, logic present, logic last, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.byte_present <= present;
    in_if.msg_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_message(int n, bit gaps, bit end_alone);
    for (int i = 0; i < n; i++)
      send_request(8'($urandom_range(0, 255)), 1'b1, (i == n - 1) && !end_alone, gaps);
    if (end_alone || n == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, gaps);
  endtask

  initial begin
    int sent;
    int n;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_request(8'hff, 1'b0, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0, 1'b0);
    send_request(8'h55, 1'b0, 1'b0, 1'b0);
    send_request(8'hff, 1'b0, 1'b1, 1'b0);
    send_request(8'h61, 1'b1, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0, 1'b0);
    send_request(8'h63, 1'b1, 1'b1, 1'b0);
    quiet_mode = 1'b1;
    send_message(55, 1'b0, 1'b0);
    send_message(56, 1'b0, 1'b1);
    quiet_mode = 1'b0;
    sent = 128;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_message(3, 1'b0, 1'b0);
        send_message(2, 1'b0, 1'b1);
        send_message(0, 1'b0, 1'b0);
      end
    join
    while (sent < 460) begin
      case ($urandom_range(0, 5))
        0: n = $urandom_range(0, 8);
        1: n = $urandom_range(54, 66);
        2: n = $urandom_range(118, 130);
        default: n = $urandom_range(0, 40);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
        sent += 1;
      end
      send_message(n, 1'b1, 1'($urandom_range(0, 1)));
      sent += n + 1;
    end
    in_if.valid <= 1'b0;
    while (sb.digest_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0 && sb.digest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
